### hdl/newton_square_root_core_macros.svh
// assertion macros for the newton square root core
`ifndef NEWTON_SQUARE_ROOT_CORE_MACROS_SVH
`define NEWTON_SQUARE_ROOT_CORE_MACROS_SVH
`ifndef SYNTH
// plain property checked on every clock edge out of reset
`define NSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in this cycle implies consequent in the next
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define NSR_ASSERT(lbl, prop, msg)
`define NSR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/nsr_pkg.sv
// shared constants, types and helpers of the newton square root core
`default_nettype none
package nsr_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int RAD_W       = 32;
  localparam int ROOT_W      = 24;
  localparam int SCALED_W    = RAD_W + FRAC_BITS;
  localparam int CNT_W       = $clog2(SCALED_W);
  localparam int LIMIT_W     = 7;
  localparam int PADDR_W     = 2;
  localparam int PDATA_W     = 32;

  localparam logic [LIMIT_W-1:0]  LIMIT_MAX   = LIMIT_W'(64);
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET = LIMIT_W'(32);
  localparam logic [ROOT_W-1:0]   ROOT_MAX    = {ROOT_W{1'b1}};
  localparam logic [PADDR_W-1:0]  ADDR_LIMIT  = PADDR_W'(0);

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic update;
    logic out_load;
  } nsr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic s_zero;
    logic div_last;
    logic stop;
  } nsr_stat_t;

  function automatic logic [LIMIT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] v);
    logic [LIMIT_W-1:0] r;
    r = v;
    if (v == '0) r = LIMIT_W'(1);
    else if (v > LIMIT_MAX) r = LIMIT_MAX;
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/nsr_if.sv
// valid/ready channel interfaces for radicands and roots
`default_nettype none
interface nsr_in_if import nsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RAD_W-1:0]  radicand;
  modport source (output valid, output radicand, input ready);
  modport sink   (input valid, input radicand, output ready);
endinterface

interface nsr_out_if import nsr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROOT_W-1:0] root;
  logic              settled;
  modport source (output valid, output root, output settled, input ready);
  modport sink   (input valid, input root, input settled, output ready);
endinterface
`default_nettype wire

### hdl/newton_square_root_core.sv
// newton square root core: takes an unsigned Q16.16 radicand on in_ch and
// returns the Q8.16 root, saturated to 24 bits, with a settled flag on out_ch.
// both channels move a transaction when valid and ready are high at a clock edge.
// one radicand is worked at a time; in_ch.ready is high only while idle.
// each newton step sets up the divider, runs the bit-per-cycle restoring
// division of the 48-bit scaled radicand, then updates the estimate.
// a nonzero radicand runs k steps before it reaches the output register, k from
// 1 to iteration_limit (at most 64); a zero radicand skips the division and
// goes straight to the output register.
// the apb register at address 0 holds iteration_limit (7 bits, reset 32);
// 0 acts as 1 and values above 64 act as 64. write it only while idle.
// the result sits in an output register: a new radicand is taken while it waits,
// and a finished root stalls in the core until the receiver takes the previous one.
// reset (rst_n low, synchronous) empties the core and restores the limit.
`default_nettype none
`include "newton_square_root_core_macros.svh"
module newton_square_root_core import nsr_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  nsr_in_if.sink                  in_ch,
  nsr_out_if.source               out_ch,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  logic [LIMIT_W-1:0] limit_r;
  logic               cfg_wr;
  nsr_cmd_t           cmd;
  nsr_stat_t          st;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_LIMIT);
  assign prdata = (paddr == ADDR_LIMIT) ? PDATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  nsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  nsr_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .radicand (in_ch.radicand),
    .limit    (limit_r),
    .st       (st),
    .root     (out_ch.root),
    .settled  (out_ch.settled)
  );

  // a taken radicand leaves the core busy in the next cycle
  `NSR_ASSERT_NEXT(a_busy_after_take, in_ch.valid && in_ch.ready, !in_ch.ready, "core still ready after taking a radicand")
  // only a zero radicand yields a zero root, and it always settles
  `NSR_ASSERT(a_zero_root_settled, !(out_ch.valid && (out_ch.root == '0)) || out_ch.settled, "zero root without settled flag")
  // a register write lands in the limit register
  `NSR_ASSERT_NEXT(a_limit_write, cfg_wr, limit_r == $past(pwdata[LIMIT_W-1:0]), "iteration limit not updated by write")

endmodule
`default_nettype wire

### hdl/nsr_datapath.sv
// estimate, restoring divider, iteration count and result register
`default_nettype none
module nsr_datapath import nsr_pkg::*; (
  input  wire logic               clk,
  input  wire nsr_cmd_t           cmd,
  input  wire logic [RAD_W-1:0]   radicand,
  input  wire logic [LIMIT_W-1:0] limit,
  output nsr_stat_t               st,
  output logic [ROOT_W-1:0]       root,
  output logic                    settled
);

  logic [RAD_W-1:0]    s_r;
  logic [SCALED_W-1:0] x_r;
  logic [LIMIT_W-1:0]  n_r;
  logic [LIMIT_W-1:0]  lim_r;
  logic [SCALED_W-1:0] rem_r;
  logic [SCALED_W-1:0] quo_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                settled_r;
  logic [ROOT_W-1:0]   root_r;
  logic                out_settled_r;

  logic [SCALED_W-1:0] x_init;
  logic [SCALED_W:0]   rem_sh;
  logic                rem_ge;
  logic [SCALED_W:0]   rem_sub;
  logic [SCALED_W:0]   sum;
  logic [SCALED_W-1:0] x_new;
  logic [LIMIT_W:0]    n_inc;

  always_comb begin
    x_init = SCALED_W'(radicand >> 1);
    if (x_init == '0) x_init = SCALED_W'(1);
    if (radicand == '0) x_init = '0;
  end

  // one quotient bit per cycle
  assign rem_sh  = {rem_r, quo_r[SCALED_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, x_r};
  assign rem_sub = rem_sh - {1'b0, x_r};

  always_comb begin
    sum   = {1'b0, x_r} + {1'b0, quo_r};
    x_new = sum[SCALED_W:1];
    if (x_new == '0) x_new = SCALED_W'(1);
  end

  assign n_inc = {1'b0, n_r} + (LIMIT_W+1)'(1);

  always_comb begin
    st.s_zero   = (s_r == '0);
    st.div_last = (cnt_r == '0);
    st.stop     = (x_new == x_r) || (n_inc >= {1'b0, lim_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r       <= radicand;
      x_r       <= x_init;
      n_r       <= '0;
      lim_r     <= clamp_limit(limit);
      settled_r <= (radicand == '0);
    end
    if (cmd.div_start) begin
      rem_r <= '0;
      quo_r <= {s_r, {FRAC_BITS{1'b0}}};
      cnt_r <= CNT_W'(SCALED_W - 1);
    end
    if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_sub[SCALED_W-1:0] : rem_sh[SCALED_W-1:0];
      quo_r <= {quo_r[SCALED_W-2:0], rem_ge};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.update) begin
      x_r       <= x_new;
      n_r       <= n_inc[LIMIT_W-1:0];
      settled_r <= (x_new == x_r);
    end
    if (cmd.out_load) begin
      root_r        <= (x_r > SCALED_W'(ROOT_MAX)) ? ROOT_MAX : x_r[ROOT_W-1:0];
      out_settled_r <= settled_r;
    end
  end

  assign root    = root_r;
  assign settled = out_settled_r;

endmodule
`default_nettype wire

### hdl/nsr_ctrl.sv
// sequencer for load, division, newton update and result hand-off
`default_nettype none
module nsr_ctrl import nsr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire nsr_stat_t st,
  output nsr_cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        if (st.s_zero) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = st.stop ? ST_FINISH : ST_DIV_INIT;
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
